@@ hw/rtl/kajt_pkg.sv @@
// package for the k-th ancestor jump table
// holds field widths, table geometry, sequencer states and entry helpers
// no dependencies
package kajt_pkg;

   // table geometry
   localparam int MAX_NODES  = 1024;
   localparam int MAX_LEVELS = 11;

   // field widths
   localparam int IDX_W  = 10;   // node index
   localparam int VAL_W  = 11;   // signed table entry, all ones is no node
   localparam int CNT_W  = 11;   // node count
   localparam int STEP_W = 10;   // k
   localparam int LVL_W  = $clog2(MAX_LEVELS + 1);

   // jump table memory
   localparam int RAM_DEPTH = MAX_LEVELS * MAX_NODES;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);

   localparam logic [VAL_W-1:0] NO_NODE = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD_ADDR,
      ST_BUILD_PARENT,
      ST_BUILD_GRAND,
      ST_QUERY_STEP,
      ST_QUERY_WAIT,
      ST_QUERY_OUT
   } state_type;

   // entries that are negative or not below the node count read as no node
   function automatic logic [VAL_W-1:0] norm_entry(input logic [VAL_W-1:0] v,
                                                   input logic [CNT_W-1:0] n);
      logic [VAL_W-1:0] r;
      r = v;
      if (v[VAL_W-1] || (CNT_W'(v[VAL_W-2:0]) >= n)) begin
         r = NO_NODE;
      end
      return r;
   endfunction

   // node count clamped to one .. MAX_NODES
   function automatic logic [CNT_W-1:0] eff_nodes(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = n;
      if (n == '0) begin
         r = CNT_W'(1);
      end else if (n > CNT_W'(MAX_NODES)) begin
         r = CNT_W'(MAX_NODES);
      end
      return r;
   endfunction

   // bit length of the node count, capped at MAX_LEVELS
   function automatic logic [LVL_W-1:0] level_total(input logic [CNT_W-1:0] n);
      logic [LVL_W-1:0] r;
      r = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (n[i]) begin
            r = LVL_W'(i + 1);
         end
      end
      if (r > LVL_W'(MAX_LEVELS)) begin
         r = LVL_W'(MAX_LEVELS);
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] table_addr(input logic [LVL_W-1:0] level,
                                                    input logic [IDX_W-1:0] node);
      return ADDR_W'(level) * ADDR_W'(MAX_NODES) + ADDR_W'(node);
   endfunction

endpackage

@@ hw/rtl/kth_ancestor_jump_table.sv @@
// top level of the k-th ancestor jump table
// depends on kajt_pkg and kajt_ram
//
// A user loads a tree's parent array one request at a time (req_type 0), with
// -1 marking the root; the load flagged last_entry starts a build of the
// binary-lifting table, level L of a node being the level L-1 ancestor of its
// level L-1 ancestor. A query (req_type 1) returns the step_count-th ancestor
// of node_index, or -1. All table traffic goes through one memory with a
// single registered read port, walked by a small sequencer, so the block takes
// one request at a time. A build visits each entry in turn: it reads the node's
// own entry one level down, then, if that is a node, that ancestor's entry one
// level down, and writes the result, over (levels - 1) x node_count entries;
// req_ready is low meanwhile. A query walks the bits of k from the bottom up,
// each set bit being one dependent memory read. A finished answer waits in the
// output register while the next request is taken. The table needs no clearing
// pass after reset. node_count is written through the csr channel; the user must
// write it only while the block is idle, which the block does not enforce.
module kth_ancestor_jump_table
   import kajt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic [IDX_W-1:0]         req_node_index,
   input  logic signed [VAL_W-1:0]  req_parent_value,
   input  logic                     req_last_entry,
   input  logic [STEP_W-1:0]        req_step_count,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [VAL_W-1:0]  rsp_ancestor,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CNT_W-1:0]         csr_node_count
);

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  node_count_ff, node_count_in;
   logic [LVL_W-1:0]  level_count_ff, level_count_in;   // levels of last build
   logic [CNT_W-1:0]  built_nodes_ff, built_nodes_in;   // zero until a build
   logic [LVL_W-1:0]  build_level_ff, build_level_in;   // level being written
   logic [IDX_W-1:0]  build_index_ff, build_index_in;
   logic [CNT_W-1:0]  build_nodes_ff, build_nodes_in;
   logic [LVL_W-1:0]  build_levels_ff, build_levels_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // query walk, payload only
   logic [VAL_W-1:0]  cur_ff, cur_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [LVL_W-1:0]  query_level_ff, query_level_in;
   logic [VAL_W-1:0]  ancestor_ff, ancestor_in;

   // memory port
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [VAL_W-1:0]  rd_data;

   logic              req_xfer;
   logic              rsp_free;
   logic [CNT_W-1:0]  start_nodes;
   logic [LVL_W-1:0]  start_levels;
   logic [VAL_W-1:0]  rd_norm_build;
   logic [VAL_W-1:0]  rd_norm_query;
   logic              last_node;
   logic              last_level;

   kajt_ram #(
      .WIDTH (VAL_W),
      .DEPTH (RAM_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_xfer     = req_valid && req_ready;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = $signed(ancestor_ff);
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   assign start_nodes   = eff_nodes(node_count_ff);
   assign start_levels  = level_total(start_nodes);
   assign rd_norm_build = norm_entry(rd_data, build_nodes_ff);
   assign rd_norm_query = norm_entry(rd_data, built_nodes_ff);
   assign last_node     = (CNT_W'(build_index_ff) == build_nodes_ff - CNT_W'(1));
   assign last_level    = (build_level_ff == build_levels_ff - LVL_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         node_count_ff   <= CNT_W'(MAX_NODES);
         level_count_ff  <= '0;
         built_nodes_ff  <= '0;
         build_level_ff  <= '0;
         build_index_ff  <= '0;
         build_nodes_ff  <= '0;
         build_levels_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         node_count_ff   <= node_count_in;
         level_count_ff  <= level_count_in;
         built_nodes_ff  <= built_nodes_in;
         build_level_ff  <= build_level_in;
         build_index_ff  <= build_index_in;
         build_nodes_ff  <= build_nodes_in;
         build_levels_ff <= build_levels_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      steps_ff       <= steps_in;
      query_level_ff <= query_level_in;
      ancestor_ff    <= ancestor_in;
   end

   always_comb begin
      state_in        = state_ff;
      node_count_in   = node_count_ff;
      level_count_in  = level_count_ff;
      built_nodes_in  = built_nodes_ff;
      build_level_in  = build_level_ff;
      build_index_in  = build_index_ff;
      build_nodes_in  = build_nodes_ff;
      build_levels_in = build_levels_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      cur_in          = cur_ff;
      steps_in        = steps_ff;
      query_level_in  = query_level_ff;
      ancestor_in     = ancestor_ff;
      wr_en           = 1'b0;
      wr_addr         = table_addr(build_level_ff, build_index_ff);
      wr_data         = NO_NODE;
      rd_en           = 1'b0;
      rd_addr         = table_addr(build_level_ff - LVL_W'(1), build_index_ff);

      if (csr_valid && csr_ready) begin
         node_count_in = csr_node_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && !req_type) begin
               // parent load into level zero
               wr_en   = 1'b1;
               wr_addr = table_addr('0, req_node_index);
               wr_data = $unsigned(req_parent_value);
               if (req_last_entry) begin
                  build_nodes_in  = start_nodes;
                  build_levels_in = start_levels;
                  build_level_in  = LVL_W'(1);
                  build_index_in  = '0;
                  if (start_levels > LVL_W'(1)) begin
                     state_in = ST_BUILD_ADDR;
                  end else begin
                     level_count_in = start_levels;
                     built_nodes_in = start_nodes;
                  end
               end
            end else if (req_xfer) begin
               cur_in         = {1'b0, req_node_index};
               steps_in       = req_step_count;
               query_level_in = '0;
               // no build, node out of range, or k deeper than the table
               if ((CNT_W'(req_node_index) >= built_nodes_ff) ||
                   ((req_step_count >> level_count_ff) != '0)) begin
                  cur_in   = NO_NODE;
                  state_in = ST_QUERY_OUT;
               end else begin
                  state_in = ST_QUERY_STEP;
               end
            end
         end

         ST_BUILD_ADDR: begin
            // read own entry one level down
            rd_en    = 1'b1;
            state_in = ST_BUILD_PARENT;
         end

         ST_BUILD_PARENT, ST_BUILD_GRAND: begin
            if ((state_ff == ST_BUILD_PARENT) && !rd_norm_build[VAL_W-1]) begin
               // follow the ancestor one level down
               rd_en    = 1'b1;
               rd_addr  = table_addr(build_level_ff - LVL_W'(1),
                                     rd_norm_build[IDX_W-1:0]);
               state_in = ST_BUILD_GRAND;
            end else begin
               wr_en    = 1'b1;
               wr_data  = rd_norm_build;
               state_in = ST_BUILD_ADDR;
               if (!last_node) begin
                  build_index_in = build_index_ff + IDX_W'(1);
               end else begin
                  build_index_in = '0;
                  if (last_level) begin
                     level_count_in = build_levels_ff;
                     built_nodes_in = build_nodes_ff;
                     state_in       = ST_IDLE;
                  end else begin
                     build_level_in = build_level_ff + LVL_W'(1);
                  end
               end
            end
         end

         ST_QUERY_STEP: begin
            if ((steps_ff == '0) || cur_ff[VAL_W-1]) begin
               state_in = ST_QUERY_OUT;
            end else if (steps_ff[0]) begin
               rd_en    = 1'b1;
               rd_addr  = table_addr(query_level_ff, cur_ff[IDX_W-1:0]);
               state_in = ST_QUERY_WAIT;
            end else begin
               steps_in       = steps_ff >> 1;
               query_level_in = query_level_ff + LVL_W'(1);
            end
         end

         ST_QUERY_WAIT: begin
            cur_in         = rd_norm_query;
            steps_in       = steps_ff >> 1;
            query_level_in = query_level_ff + LVL_W'(1);
            state_in       = ST_QUERY_STEP;
         end

         ST_QUERY_OUT: begin
            // hold until the output register is free
            if (rsp_free) begin
               ancestor_in  = cur_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/kajt_ram.sv @@
// generic simple dual port ram, one write and one registered read a cycle
// no dependencies
module kajt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ bench/kth_ancestor_jump_table_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for kth_ancestor_jump_table: loads, table builds, ancestor queries
// keeps its own binary-lifting table to predict every answer; depends on kajt_pkg and the rtl
module kth_ancestor_jump_table_test;
   import kajt_pkg::*;

   localparam int ITEM_BUDGET  = 880;    // stop opening new phases past this many items
   localparam int LOADED_NODES = 512;    // nodes loaded by the big phase
   localparam int QUIET_LIMIT  = 60000;  // long enough to outlast a 512-node build
   localparam int FAULT_SHOWN  = 10;

   typedef enum bit {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } request_kind_type;

   typedef enum int {
      DRAIN_STEADY,
      DRAIN_RANDOM,
      DRAIN_PERIODIC
   } drain_mode_type;

   typedef struct {
      request_kind_type         kind;
      logic [IDX_W-1:0]         node;
      logic signed [VAL_W-1:0]  parent;
      bit                       last;
      logic [STEP_W-1:0]        steps;
   } lift_request_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_type = 1'b0;
   logic [IDX_W-1:0]         req_node_index = '0;
   logic signed [VAL_W-1:0]  req_parent_value = '0;
   logic                     req_last_entry = 1'b0;
   logic [STEP_W-1:0]        req_step_count = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [VAL_W-1:0]  rsp_ancestor;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CNT_W-1:0]         csr_node_count = '0;

   kth_ancestor_jump_table dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_node_index   (req_node_index),
      .req_parent_value (req_parent_value),
      .req_last_entry   (req_last_entry),
      .req_step_count   (req_step_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ancestor     (rsp_ancestor),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_node_count   (csr_node_count)
   );

   initial begin : clock_gen
      forever #1 clock = ~clock;
   end

   // predictor state: jump table, register copy, geometry of the last build
   logic signed [VAL_W-1:0] lift_table [MAX_LEVELS][MAX_NODES];
   int                      count_setting = MAX_NODES;
   int                      lift_depth = 0;
   int                      lift_nodes = 0;   // zero until the first build

   lift_request_type         pending_requests [$];
   logic signed [VAL_W-1:0]  expected_answers [$];
   int                       queued_items = 0;
   int                       fault_count = 0;
   int                       answers_seen = 0;
   int                       quiet_cycles = 0;

   // table entry, with anything outside [0, span) read as no ancestor
   function automatic int lift_read(input int level, input int node, input int span);
      int v;
      v = lift_table[level][node];
      return (v < 0 || v >= span) ? -1 : v;
   endfunction

   // one accepted transfer: loads update level 0 and may rebuild, queries climb
   function automatic void lift_step(input request_kind_type kind, input int node,
                                     input logic signed [VAL_W-1:0] parent, input bit last,
                                     input int steps, output bit answered,
                                     output logic signed [VAL_W-1:0] answer);
      int span;
      int levels;
      int t;
      int cur;
      answered = 1'b0;
      answer = NO_NODE;
      if (kind == REQ_LOAD) begin
         lift_table[0][node] = parent;
         if (last) begin
            span = (count_setting == 0) ? 1 :
                   (count_setting > MAX_NODES) ? MAX_NODES : count_setting;
            levels = 0;
            t = span;
            while (t != 0) begin
               levels++;
               t = t >> 1;
            end
            if (levels > MAX_LEVELS) begin
               levels = MAX_LEVELS;
            end
            for (int lv = 1; lv < levels; lv++) begin
               for (int j = 0; j < span; j++) begin
                  cur = lift_read(lv - 1, j, span);
                  lift_table[lv][j] = (cur < 0) ? NO_NODE : VAL_W'(lift_read(lv - 1, cur, span));
               end
            end
            lift_depth = levels;
            lift_nodes = span;
         end
      end else begin
         answered = 1'b1;
         cur = -1;
         if (lift_nodes != 0 && node < lift_nodes && (steps >> lift_depth) == 0) begin
            cur = node;
            for (int i = 0; i < lift_depth; i++) begin
               if (cur >= 0 && ((steps >> i) & 1) != 0) begin
                  cur = lift_read(i, cur, lift_nodes);
               end
            end
         end
         answer = VAL_W'(cur);
      end
   endfunction

   task automatic note_fault(input string what);
      fault_count++;
      if (fault_count <= FAULT_SHOWN) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   // ---------------------------------------------------------------- driver
   lift_request_type head;
   int               burst_left = 0;
   int               gap_left = 0;
   logic             req_taken = 1'b0;   // transfer seen at the last rising edge

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0 || pending_requests.size() == 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end
            req_valid <= 1'b0;
         end else begin
            head = pending_requests.pop_front();
            req_valid        <= 1'b1;
            req_type         <= head.kind;
            req_node_index   <= head.node;
            req_parent_value <= head.parent;
            req_last_entry   <= head.last;
            req_step_count   <= head.steps;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // new burst; a quarter of them follow on without a gap
               burst_left = $urandom_range(0, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
      end
   end

   // -------------------------------------------------------------- receiver
   drain_mode_type drain_mode = DRAIN_STEADY;
   int             mode_left = 0;
   int             hold_left = 0;
   int             next_hold_at = 60;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (answers_seen >= next_hold_at) begin
         // long hold-off so the output register fills and the input backs up
         hold_left = 400;
         next_hold_at += 640;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            drain_mode = drain_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (drain_mode)
            DRAIN_STEADY: begin
               rsp_ready <= 1'b1;
            end
            DRAIN_RANDOM: begin
               rsp_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_ready <= (mode_left % 4 == 0);
            end
         endcase
      end
   end

   // --------------------------------------------------------------- monitor
   bit                      answered;
   logic signed [VAL_W-1:0] answer;
   logic signed [VAL_W-1:0] want;

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         // check the result first, a transfer on req this edge cannot be its source
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
               note_fault($sformatf("ancestor %0d with no query outstanding", rsp_ancestor));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_ancestor !== want) begin
                  note_fault($sformatf("ancestor mismatch: expected %0d, got %0d",
                                       want, rsp_ancestor));
               end
            end
         end
         if (req_valid && req_ready) begin
            lift_step(request_kind_type'(req_type), req_node_index, req_parent_value,
                      req_last_entry, req_step_count, answered, answer);
            if (answered) begin
               expected_answers.push_back(answer);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("tb: failure");
      $finish;
   end

   // -------------------------------------------------------------- stimulus
   task automatic push_load(input int node, input int parent, input bit last);
      lift_request_type r;
      r.kind = REQ_LOAD;
      r.node = IDX_W'(node);
      r.parent = VAL_W'(parent);
      r.last = last;
      r.steps = STEP_W'($urandom);
      pending_requests.push_back(r);
      queued_items++;
   endtask

   task automatic push_query(input int node, input int steps);
      lift_request_type r;
      r.kind = REQ_QUERY;
      r.node = IDX_W'(node);
      r.parent = VAL_W'($urandom);
      r.last = $urandom_range(0, 1);
      r.steps = STEP_W'(steps);
      pending_requests.push_back(r);
      queued_items++;
   endtask

   // mostly chains and earlier nodes for deep trees, some roots and bad parents
   function automatic int pick_parent(input int node, input int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5 || (r >= 10 && node == 0)) begin
         return -1;
      end else if (r < 10) begin
         if (span < MAX_NODES && $urandom_range(0, 1) == 1) begin
            return $urandom_range(span, MAX_NODES - 1);
         end
         return -int'($urandom_range(2, 1024));
      end else if (r < 60) begin
         return node - 1;
      end
      return $urandom_range(0, node - 1);
   endfunction

   // query section of a phase, some stray loads and rebuilds mixed in, ends on a query
   task automatic push_query_mix(input int span, input int count);
      int r;
      int top;
      int k;
      top = (1 << $clog2(span + 1)) - 1;
      if (top > 1023) begin
         top = 1023;
      end
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (i < count - 1 && r < 10) begin
            push_load($urandom_range(0, MAX_NODES - 1), pick_parent(
                      $urandom_range(0, MAX_NODES - 1), span), 1'b0);
         end else if (i < count - 1 && r < 13) begin
            k = $urandom_range(0, span - 1);
            push_load(k, pick_parent(k, span), 1'b1);
         end else begin
            r = $urandom_range(0, 99);
            k = (r < 45) ? $urandom_range(0, top) :
                (r < 85) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
            if ($urandom_range(0, 99) < 85) begin
               push_query($urandom_range(0, span - 1), k);
            end else begin
               push_query($urandom_range(0, MAX_NODES - 1), k);
            end
         end
      end
   endtask

   task automatic write_node_count(input logic [CNT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_node_count <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      count_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // every item sent and answered; phases end on a query so no build is left running
   task automatic settle();
      while (pending_requests.size() != 0 || req_valid || expected_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
   endtask

   initial begin : stimulus
      int setting;
      int span;
      int node;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // one node: query before any build, then k and node out of range
      write_node_count(11'd1);
      push_query(0, 0);
      push_load(0, -1, 1'b1);
      push_query(0, 0);
      push_query(0, 1);
      push_query(1023, 1023);
      settle();

      // zero count acts as one, node is its own parent
      write_node_count(11'd0);
      push_load(0, 0, 1'b1);
      push_query(0, 1);
      settle();

      // eight-node chain with one parent past the count and one far negative
      write_node_count(11'd8);
      for (int j = 0; j < 8; j++) begin
         push_load(j, (j == 5) ? 1023 : (j == 6) ? -1024 : j - 1, j == 7);
      end
      push_query(4, 3);
      push_query(4, 4);
      push_query(7, 1);
      push_query(7, 2);
      push_query(3, 8);
      // a load after the build changes level 0 only
      push_load(2, -1, 1'b0);
      push_query(3, 1);
      push_query(4, 2);
      push_query(4, 3);
      settle();

      // big table with parents past the count now and then, then a rebuild one node smaller
      write_node_count(CNT_W'(LOADED_NODES));
      for (int j = 0; j < LOADED_NODES; j++) begin
         push_load(j, pick_parent(j, LOADED_NODES), j == LOADED_NODES - 1);
      end
      push_query_mix(LOADED_NODES, 40);
      settle();
      write_node_count(CNT_W'(LOADED_NODES - 1));
      node = $urandom_range(0, LOADED_NODES - 2);
      push_load(node, pick_parent(node, LOADED_NODES - 1), 1'b1);
      push_query_mix(LOADED_NODES - 1, 30);
      settle();

      // every node below LOADED_NODES is loaded now, so any count up to it can be rebuilt
      while (queued_items < ITEM_BUDGET) begin
         case ($urandom_range(0, 19))
            0: setting = 0;
            1: setting = 1;
            2, 3, 4, 5, 6, 7, 8, 9, 10, 11: setting = $urandom_range(2, 32);
            default: setting = $urandom_range(33, LOADED_NODES);
         endcase
         span = (setting == 0) ? 1 : setting;
         write_node_count(CNT_W'(setting));
         if (span <= 48) begin
            for (int j = 0; j < span; j++) begin
               push_load(j, pick_parent(j, span), j == span - 1);
            end
         end else begin
            for (int j = 0; j < 24; j++) begin
               node = $urandom_range(0, span - 1);
               push_load(node, pick_parent(node, span), j == 23);
            end
         end
         push_query_mix(span, $urandom_range(15, 45));
         settle();
      end

      if (fault_count == 0 && expected_answers.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
